// ===== rtl/core/ipgf_pkg.sv =====
// ----------------------------------------------------------------------------
// ipgf_pkg
// Shared types and constants for the infrared pulse gap framer.
// ----------------------------------------------------------------------------
package ipgf_pkg;

  localparam int TS_W    = 16;
  localparam int GAP_W   = 15;
  localparam int CNT_W   = 8;
  localparam int CMD_W   = 2;

  // gap register value after reset
  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(10000);

  // age at which an idle poll pulls the last timestamp forward
  localparam logic [TS_W-1:0] AGE_LIMIT = 16'h8000;

  typedef enum logic [CMD_W-1:0] {
    CMD_EDGE   = 2'd0,
    CMD_POLL   = 2'd1,
    CMD_ARM    = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // one input beat
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [TS_W-1:0]  timestamp;
  } item_t;

  // framer state
  typedef struct packed {
    logic [TS_W-1:0]  last_time;
    logic             recording;
    logic             edge_parity;
    logic [CNT_W-1:0] stored_count;
    logic             armed;
  } state_t;

  // one result beat
  typedef struct packed {
    logic             has_duration;
    logic [TS_W-1:0]  duration;
    logic             frame_end;
    logic [CNT_W-1:0] frame_length;
  } result_t;

endpackage

// ===== rtl/core/ipgf_step.sv =====
// ----------------------------------------------------------------------------
// ipgf_step
// Single-pass update: takes one item and the current state, gives the next
// state and at most one result.
// ----------------------------------------------------------------------------
module ipgf_step #(
  parameter int MAX_DURATIONS = 128
) (
  input  ipgf_pkg::item_t                  item,
  input  ipgf_pkg::state_t                 st,
  input  logic [ipgf_pkg::GAP_W-1:0]       gap_len,
  output ipgf_pkg::state_t                 st_nxt,
  output ipgf_pkg::result_t                res,
  output logic                             res_vld
);

  localparam logic [ipgf_pkg::CNT_W-1:0] MAX_CNT = ipgf_pkg::CNT_W'(MAX_DURATIONS);

  logic [ipgf_pkg::TS_W-1:0]  age;
  logic [ipgf_pkg::TS_W-1:0]  gap_ext;
  logic                       gap_gt;
  logic                       gap_ge;
  logic                       rec_new;
  logic [ipgf_pkg::CNT_W-1:0] cnt_inc;

  // interval since the last edge, modulo the timer width
  assign age     = item.timestamp - st.last_time;
  assign gap_ext = {1'b0, gap_len};
  assign gap_gt  = age > gap_ext;
  assign gap_ge  = age >= gap_ext;
  assign rec_new = st.recording | (gap_gt & ~st.edge_parity);
  assign cnt_inc = st.stored_count + 1'b1;

  // state update and result selection
  always_comb begin
    st_nxt  = st;
    res     = '0;
    res_vld = 1'b0;
    case (ipgf_pkg::cmd_t'(item.command))
      ipgf_pkg::CMD_ARM: begin
        st_nxt.last_time    = item.timestamp;
        st_nxt.recording    = 1'b0;
        st_nxt.edge_parity  = 1'b0;
        st_nxt.stored_count = '0;
        st_nxt.armed        = 1'b1;
      end
      ipgf_pkg::CMD_EDGE: begin
        if (st.armed) begin
          if (gap_gt && !st.edge_parity && st.recording) begin
            // gap at a mark edge closes the frame, edge not recorded
            st_nxt.armed     = 1'b0;
            res.frame_end    = 1'b1;
            res.frame_length = st.stored_count;
            res_vld          = 1'b1;
          end else begin
            st_nxt.last_time   = item.timestamp;
            st_nxt.edge_parity = ~st.edge_parity;
            st_nxt.recording   = rec_new;
            if (rec_new) begin
              st_nxt.stored_count = cnt_inc;
              res.has_duration    = 1'b1;
              res.duration        = age;
              res_vld             = 1'b1;
              if (cnt_inc == MAX_CNT) begin
                // frame full
                st_nxt.armed     = 1'b0;
                res.frame_end    = 1'b1;
                res.frame_length = cnt_inc;
              end
            end
          end
        end
      end
      ipgf_pkg::CMD_POLL: begin
        if (st.armed) begin
          if (st.recording) begin
            if (gap_ge) begin
              st_nxt.armed     = 1'b0;
              res.frame_end    = 1'b1;
              res.frame_length = st.stored_count;
              res_vld          = 1'b1;
            end
          end else if (age >= ipgf_pkg::AGE_LIMIT) begin
            // keep the idle age from wrapping
            st_nxt.last_time = item.timestamp - gap_ext;
          end
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule

// ===== rtl/core/ir_pulse_gap_framer.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_gap_framer
// Frames raw infrared edge timestamps into durations separated by idle gaps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per edge capture,
//   poll or arm command, with a 16-bit timer value. Result channel
//   (out_valid/out_ready) carries at most one beat per input beat: a
//   recorded duration, an end-of-frame marker with the frame length, or
//   both when the frame fills up. Input beats that give no result are
//   absorbed silently.
//   The input register takes each accepted beat; the framing update then
//   loads the result register, which drives out_valid, once the result
//   slot is free or being emptied.
//   Throughput is one beat per cycle while the receiver does not stall.
//   When the receiver stalls, a held result blocks the update stage and
//   the input register fills; in_ready then drops until out_ready returns.
//   Reset clears the framer to stopped and the gap register to 10000 ticks;
//   nothing is framed until an arm command arrives. cfg_wr_en writes the
//   gap register immediately and should only be used while the block is idle.
// ----------------------------------------------------------------------------
module ir_pulse_gap_framer #(
  parameter int MAX_DURATIONS = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ipgf_pkg::GAP_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ipgf_pkg::CMD_W-1:0]    in_command,
  input  logic [ipgf_pkg::TS_W-1:0]     in_timestamp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_has_duration,
  output logic [ipgf_pkg::TS_W-1:0]     out_duration,
  output logic                          out_frame_end,
  output logic [ipgf_pkg::CNT_W-1:0]    out_frame_length
);

  logic [ipgf_pkg::GAP_W-1:0] gap_r;
  ipgf_pkg::item_t            item_r;
  logic                       item_vld_r;
  ipgf_pkg::state_t           st_r;
  ipgf_pkg::state_t           st_nxt;
  ipgf_pkg::result_t          res_nxt;
  logic                       res_vld_nxt;
  ipgf_pkg::result_t          res_r;
  logic                       res_vld_r;
  logic                       go;

  // update stage advances when the result slot is free or being emptied
  assign go       = item_vld_r & (~res_vld_r | out_ready);
  assign in_ready = ~item_vld_r | go;

  // gap register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= ipgf_pkg::GAP_RESET;
    end else if (cfg_wr_en) begin
      gap_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.command   <= in_command;
      item_r.timestamp <= in_timestamp;
    end
  end

  // framing update
  ipgf_step #(
    .MAX_DURATIONS(MAX_DURATIONS)
  ) u_step (
    .item      (item_r),
    .st        (st_r),
    .gap_len   (gap_r),
    .st_nxt    (st_nxt),
    .res       (res_nxt),
    .res_vld   (res_vld_nxt)
  );

  // framer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (go) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (go) begin
      res_vld_r <= res_vld_nxt;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_vld_nxt) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = res_vld_r;
  assign out_has_duration = res_r.has_duration;
  assign out_duration     = res_r.duration;
  assign out_frame_end    = res_r.frame_end;
  assign out_frame_length = res_r.frame_length;

  // a closing beat always leaves the framer stopped
  a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res_vld_nxt && res_nxt.frame_end) |=> !st_r.armed)
    else $error("framer still armed after frame end");

  // a recorded duration only comes from a recording framer
  a_dur_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res_vld_nxt && res_nxt.has_duration) |=> st_r.recording)
    else $error("duration emitted while not recording");

  // count stays clear outside a frame
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.recording |-> (st_r.stored_count == '0))
    else $error("stored count nonzero while not recording");

  // count never passes the frame limit
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.stored_count <= ipgf_pkg::CNT_W'(MAX_DURATIONS))
    else $error("stored count beyond frame limit");

  // a held result is not overwritten by the update stage
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && !out_ready) |-> !go)
    else $error("result register overwritten while stalled");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the infrared pulse gap framer. A short table of
// edge, poll and arm beats covers the corner cases, then state-aware random
// traffic builds frames of random length, some of them filled to the limit,
// under several gap settings and handshake stall patterns. Every result beat
// is checked field by field against a behavioural model of the framer.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_DURATIONS = 128;
  localparam int RUN_LIMIT     = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int N_ROWS        = 23;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [ipgf_pkg::GAP_W-1:0]     cfg_wr_data;
  logic                           in_valid;
  logic                           in_ready;
  logic [ipgf_pkg::CMD_W-1:0]     in_command;
  logic [ipgf_pkg::TS_W-1:0]      in_timestamp;
  logic                           out_valid;
  logic                           out_ready;
  logic                           out_has_duration;
  logic [ipgf_pkg::TS_W-1:0]      out_duration;
  logic                           out_frame_end;
  logic [ipgf_pkg::CNT_W-1:0]     out_frame_length;

  // one row of the directed table
  typedef struct packed {
    ipgf_pkg::cmd_t            cmd;
    logic [ipgf_pkg::TS_W-1:0] ts;
    logic                      typed;
    ipgf_pkg::result_t         want;
  } stim_row_t;

  stim_row_t                  plan [N_ROWS];
  ipgf_pkg::result_t          owed_beats [$];
  ipgf_pkg::state_t           fr;
  logic [ipgf_pkg::GAP_W-1:0] gap_reg;
  int unsigned                frame_goal;
  int unsigned                tx_idle_pct;
  int unsigned                rx_idle_pct;
  int                         mismatches;
  int                         cycle_count;

  ir_pulse_gap_framer #(
    .MAX_DURATIONS(MAX_DURATIONS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_timestamp     (in_timestamp),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_has_duration (out_has_duration),
    .out_duration     (out_duration),
    .out_frame_end    (out_frame_end),
    .out_frame_length (out_frame_length)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // framer model: steps one accepted beat, returns 1 when a result is due
  function automatic bit predict_framing(input ipgf_pkg::cmd_t c,
                                         input logic [ipgf_pkg::TS_W-1:0] ts,
                                         output ipgf_pkg::result_t r);
    logic [ipgf_pkg::TS_W-1:0] age;
    age = ts - fr.last_time;
    r = '0;
    if (c == ipgf_pkg::CMD_ARM) begin
      fr.last_time    = ts;
      fr.recording    = 1'b0;
      fr.edge_parity  = 1'b0;
      fr.stored_count = '0;
      fr.armed        = 1'b1;
      return 1'b0;
    end
    if (!fr.armed || c == ipgf_pkg::CMD_UNUSED)
      return 1'b0;
    if (c == ipgf_pkg::CMD_EDGE) begin
      // long gap landing on a mark edge opens or closes a frame
      if (age > ipgf_pkg::TS_W'(gap_reg) && !fr.edge_parity) begin
        if (fr.recording) begin
          fr.armed       = 1'b0;
          r.frame_end    = 1'b1;
          r.frame_length = fr.stored_count;
          return 1'b1;
        end
        fr.recording = 1'b1;
      end
      fr.last_time   = ts;
      fr.edge_parity = ~fr.edge_parity;
      if (!fr.recording)
        return 1'b0;
      fr.stored_count = fr.stored_count + 1'b1;
      r.has_duration  = 1'b1;
      r.duration      = age;
      // frame full
      if (fr.stored_count == ipgf_pkg::CNT_W'(MAX_DURATIONS)) begin
        fr.armed       = 1'b0;
        r.frame_end    = 1'b1;
        r.frame_length = fr.stored_count;
      end
      return 1'b1;
    end
    // poll: closes a frame on a long age, or drags an idle timestamp along
    if (fr.recording) begin
      if (age >= ipgf_pkg::TS_W'(gap_reg)) begin
        fr.armed       = 1'b0;
        r.frame_end    = 1'b1;
        r.frame_length = fr.stored_count;
        return 1'b1;
      end
    end else if (age >= ipgf_pkg::AGE_LIMIT) begin
      fr.last_time = ts - ipgf_pkg::TS_W'(gap_reg);
    end
    return 1'b0;
  endfunction

  // drive one input beat from a falling edge, model it on acceptance
  task automatic send_beat(input ipgf_pkg::cmd_t c, input logic [ipgf_pkg::TS_W-1:0] ts,
                           input logic typed, input ipgf_pkg::result_t want);
    ipgf_pkg::result_t r;
    bit                due;
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= c;
    in_timestamp <= ts;
    do @(posedge clk); while (!in_ready);
    due = predict_framing(c, ts, r);
    if (typed)
      owed_beats.push_back(want);
    else if (due)
      owed_beats.push_back(r);
    @(negedge clk);
  endtask

  // let every owed beat arrive and the pipeline empty
  task automatic drain_block();
    in_valid <= 1'b0;
    while (owed_beats.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_gap(input logic [ipgf_pkg::GAP_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    gap_reg = v;
  endtask

  // state-aware traffic: mostly well-formed frames, some noise
  task automatic random_traffic(input int unsigned n_beats);
    int unsigned               counted;
    int unsigned               pick;
    int unsigned               span;
    ipgf_pkg::cmd_t            c;
    logic [ipgf_pkg::TS_W-1:0] ts;
    counted = 0;
    while (counted < n_beats) begin
      pick = $urandom_range(99, 0);
      c    = ipgf_pkg::CMD_EDGE;
      span = $urandom_range(gap_reg, 0);
      if (!fr.armed) begin
        if (pick < 80) begin
          c = ipgf_pkg::CMD_ARM;
          frame_goal = ($urandom_range(5, 0) == 0) ? 255 : $urandom_range(24, 1);
        end else begin
          c = ipgf_pkg::cmd_t'($urandom_range(3, 0));
        end
        ts = ipgf_pkg::TS_W'($urandom);
      end else if (!fr.recording) begin
        // waiting for the opening gap
        if (pick < 55) begin
          span = $urandom_range(32'hFFFF, gap_reg + 1);
        end else if (pick < 70) begin
          c    = ipgf_pkg::CMD_POLL;
          span = ($urandom_range(1, 0) == 1) ? $urandom_range(32'hFFFF, 32'h8000)
                                              : $urandom_range(32'h7FFF, 0);
        end else if (pick >= 95) begin
          c    = ipgf_pkg::cmd_t'($urandom_range(3, 0));
          span = $urandom_range(32'hFFFF, 0);
        end
        ts = fr.last_time + ipgf_pkg::TS_W'(span);
      end else if (fr.stored_count < ipgf_pkg::CNT_W'(frame_goal)) begin
        // inside a frame: short intervals, the odd short poll or stray beat
        if (pick >= 88 && pick < 94 && gap_reg != '0) begin
          c    = ipgf_pkg::CMD_POLL;
          span = $urandom_range(gap_reg - 1, 0);
        end else if (pick >= 94 && pick < 97) begin
          c    = ipgf_pkg::CMD_UNUSED;
          span = $urandom_range(32'hFFFF, 0);
        end else if (pick >= 97) begin
          span = $urandom_range(32'hFFFF, gap_reg + 1);
        end
        ts = fr.last_time + ipgf_pkg::TS_W'(span);
      end else begin
        // frame long enough: close it by gap edge or poll
        if (pick < 50) begin
          span = $urandom_range(32'hFFFF, gap_reg + 1);
        end else begin
          c    = ipgf_pkg::CMD_POLL;
          span = $urandom_range(32'hFFFF, gap_reg);
        end
        ts = fr.last_time + ipgf_pkg::TS_W'(span);
      end
      counted++;
      send_beat(c, ts, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // result side: random back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    ipgf_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_beats.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, got %0d/%0d/%0d/%0d",
                 $time, out_has_duration, out_duration, out_frame_end, out_frame_length);
      end else begin
        want = owed_beats.pop_front();
        check_field("has_duration", want.has_duration, out_has_duration);
        check_field("duration", want.duration, out_duration);
        check_field("frame_end", want.frame_end, out_frame_end);
        check_field("frame_length", want.frame_length, out_frame_length);
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus sequence
  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_command   = ipgf_pkg::CMD_EDGE;
    in_timestamp = '0;
    out_ready    = 1'b0;
    mismatches   = 0;
    fr           = '0;
    gap_reg      = ipgf_pkg::GAP_RESET;
    frame_goal   = 8;
    tx_idle_pct  = 19;
    rx_idle_pct  = 67;

    // directed corner cases, default gap of 10000 ticks
    plan = '{
      '{ipgf_pkg::CMD_EDGE,   16'h0000,  1'b0, '0},                 // ignored, not armed
      '{ipgf_pkg::CMD_POLL,   16'hFFFF,  1'b0, '0},
      '{ipgf_pkg::CMD_UNUSED, 16'hFFFF,  1'b0, '0},
      '{ipgf_pkg::CMD_ARM,    16'h0000,  1'b0, '0},
      '{ipgf_pkg::CMD_EDGE,   16'd5000,  1'b0, '0},                 // short gap, no start
      '{ipgf_pkg::CMD_EDGE,   16'd20000, 1'b0, '0},                 // long gap on space edge
      '{ipgf_pkg::CMD_POLL,   16'd25000, 1'b0, '0},
      '{ipgf_pkg::CMD_EDGE,   16'd30001, 1'b1, '{1'b1, 16'd10001, 1'b0, 8'd0}}, // opens
      '{ipgf_pkg::CMD_EDGE,   16'd30500, 1'b0, '0},
      '{ipgf_pkg::CMD_UNUSED, 16'h0000,  1'b0, '0},
      '{ipgf_pkg::CMD_POLL,   16'd30600, 1'b0, '0},
      '{ipgf_pkg::CMD_EDGE,   16'hFFFF,  1'b1, '{1'b0, 16'd0, 1'b1, 8'd2}},     // gap closes
      '{ipgf_pkg::CMD_EDGE,   16'd100,   1'b0, '0},                 // stopped
      '{ipgf_pkg::CMD_ARM,    16'hFFF0,  1'b0, '0},
      '{ipgf_pkg::CMD_EDGE,   16'd10240, 1'b1, '{1'b1, 16'd10256, 1'b0, 8'd0}}, // wrapped
      '{ipgf_pkg::CMD_EDGE,   16'd10256, 1'b0, '0},
      '{ipgf_pkg::CMD_POLL,   16'd20256, 1'b1, '{1'b0, 16'd0, 1'b1, 8'd2}},     // poll closes
      '{ipgf_pkg::CMD_ARM,    16'h0000,  1'b0, '0},
      '{ipgf_pkg::CMD_POLL,   16'h8000,  1'b0, '0},                 // idle timestamp pulled
      '{ipgf_pkg::CMD_EDGE,   16'h8001,  1'b1, '{1'b1, 16'd10001, 1'b0, 8'd0}},
      '{ipgf_pkg::CMD_POLL,   16'h7FFF,  1'b1, '{1'b0, 16'd0, 1'b1, 8'd1}},
      '{ipgf_pkg::CMD_ARM,    16'hFFFF,  1'b0, '0},
      '{ipgf_pkg::CMD_EDGE,   16'h0000,  1'b0, '0}
    };

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_ROWS; i++)
      send_beat(plan[i].cmd, plan[i].ts, plan[i].typed, plan[i].want);
    random_traffic(205);

    // further gap settings, extremes first
    for (int ph = 1; ph < 6; ph++) begin
      drain_block();
      if (ph >= 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (ph >= 2) begin
        tx_idle_pct = 67;
        rx_idle_pct = 19;
      end
      case (ph)
        1: begin
          write_gap(15'h7FFF);
        end
        2: begin
          write_gap('0);
        end
        3: begin
          write_gap(15'd1);
        end
        4: begin
          write_gap(ipgf_pkg::GAP_W'($urandom_range(32'h7FFF, 1)));
        end
        default: begin
          write_gap(ipgf_pkg::GAP_W'($urandom_range(2000, 100)));
        end
      endcase
      random_traffic(225);
    end

    drain_block();
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
